// ===== design/rpn_pkg.sv =====
package rpn_pkg;

    // Default sizes of the stack and of one stored value
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int STACK_DEPTH_DEF = 16;

    // Fixed widths of the word fields
    localparam int MODE_W   = 3;
    localparam int OPND_W   = 32;
    localparam int DEPTH_W  = 5;
    localparam int STATUS_W = 3;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT   = 3'd4;

    // Stack update applied when a word completes
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_PUSH    = 2'd1,
        ACT_REPLACE = 2'd2
    } act_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                load_in;
        logic                addsub;
        logic                sub;
        logic                mul_init;
        logic                div_init;
        logic                mul_step;
        logic                div_step;
        logic                norm;
        logic                commit;
        act_t                act;
        logic [STATUS_W-1:0] out_status;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic few;
        logic rhs_zero;
        logic sat;
    } stat_t;

endpackage

// ===== design/rpn_if.sv =====
interface rpn_in_if;
    logic                               valid;
    logic                               ready;
    logic [rpn_pkg::MODE_W-1:0]         mode;
    logic signed [rpn_pkg::OPND_W-1:0]  operand;

    modport source (output valid, output mode, output operand, input ready);
    modport sink (input valid, input mode, input operand, output ready);
endinterface

interface rpn_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rpn_pkg::OPND_W-1:0]  top_value;
    logic [rpn_pkg::DEPTH_W-1:0]        stack_depth;
    logic [rpn_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output top_value, output stack_depth, output status,
                    input ready);
    modport sink (input valid, input top_value, input stack_depth, input status,
                  output ready);
endinterface

// ===== design/rpn_dpath.sv =====
module rpn_dpath #(
    parameter int DATA_WIDTH  = rpn_pkg::DATA_WIDTH_DEF,
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rpn_pkg::cmd_t                      cmd,
    output rpn_pkg::stat_t                     stat,
    input  logic signed [rpn_pkg::OPND_W-1:0]  operand,
    output logic signed [rpn_pkg::OPND_W-1:0]  top_value,
    output logic [rpn_pkg::DEPTH_W-1:0]        stack_depth,
    output logic [rpn_pkg::STATUS_W-1:0]       status
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = DATA_WIDTH / 2;
    localparam int QW = 2 * DATA_WIDTH - DATA_WIDTH / 2;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH + 1);

    localparam logic [W-1:0]  SMIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]  SMAX  = ~SMIN;
    localparam logic [QW-1:0] QHALF = {{(QW-W){1'b0}}, SMIN};

    logic [W-1:0]  mem [STACK_DEPTH];

    logic [SW-1:0] sp_reg, sp_next;
    logic [W-1:0]  top_reg, top_next;
    logic [W-1:0]  rd_reg;
    logic [W-1:0]  opnd_reg;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [QW-1:0] shf_reg, shf_next;
    logic          neg_reg, neg_next;
    logic          mul_reg, mul_next;
    logic [W-1:0]  res_reg, res_next;
    logic          sat_reg, sat_next;
    logic [rpn_pkg::OPND_W-1:0]   top_value_reg;
    logic [rpn_pkg::DEPTH_W-1:0]  depth_reg;
    logic [rpn_pkg::STATUS_W-1:0] status_reg;

    logic [W-1:0]  lhs, rhs, lhs_mag, rhs_mag;
    logic [W-1:0]  rhs_op, sum;
    logic          ovf;
    logic [W:0]    msum, rem_sh, diff;
    logic          ge;
    logic [QW-1:0] q;
    logic          over;

    // Left operand sits in memory below the cached top entry
    assign lhs     = rd_reg;
    assign rhs     = top_reg;
    assign lhs_mag = lhs[W-1] ? (~lhs + W'(1)) : lhs;
    assign rhs_mag = rhs[W-1] ? (~rhs + W'(1)) : rhs;

    // Add or subtract with clamping
    assign rhs_op = cmd.sub ? ~rhs : rhs;
    assign sum    = lhs + rhs_op + W'(cmd.sub);
    assign ovf    = (lhs[W-1] == rhs_op[W-1]) && (sum[W-1] != lhs[W-1]);

    // One shift-add multiply step
    assign msum = {1'b0, acc_reg} + (shf_reg[0] ? {1'b0, a_reg} : '0);

    // One restoring divide step
    assign rem_sh = {acc_reg, shf_reg[QW-1]};
    assign ge     = rem_sh >= {1'b0, a_reg};
    assign diff   = rem_sh - {1'b0, a_reg};

    // Scaled magnitude and its clamp test
    assign q    = mul_reg ? {acc_reg, shf_reg[W-1:F]} : shf_reg;
    assign over = neg_reg ? (q > QHALF) : (q >= QHALF);

    always_comb
    begin
        a_next   = a_reg;
        acc_next = acc_reg;
        shf_next = shf_reg;
        neg_next = neg_reg;
        mul_next = mul_reg;
        res_next = res_reg;
        sat_next = sat_reg;
        if (cmd.addsub)
        begin
            res_next = ovf ? (lhs[W-1] ? SMIN : SMAX) : sum;
            sat_next = ovf;
        end
        if (cmd.mul_init)
        begin
            a_next   = lhs_mag;
            acc_next = '0;
            shf_next = QW'(rhs_mag);
            neg_next = lhs[W-1] ^ rhs[W-1];
            mul_next = 1'b1;
        end
        if (cmd.div_init)
        begin
            a_next   = rhs_mag;
            acc_next = '0;
            shf_next = QW'(lhs_mag) << F;
            neg_next = lhs[W-1] ^ rhs[W-1];
            mul_next = 1'b0;
        end
        if (cmd.mul_step)
        begin
            acc_next = msum[W:1];
            shf_next = QW'({msum[0], shf_reg[W-1:1]});
        end
        if (cmd.div_step)
        begin
            acc_next = ge ? diff[W-1:0] : rem_sh[W-1:0];
            shf_next = {shf_reg[QW-2:0], ge};
        end
        if (cmd.norm)
        begin
            res_next = over ? (neg_reg ? SMIN : SMAX)
                            : (neg_reg ? (~q[W-1:0] + W'(1)) : q[W-1:0]);
            sat_next = over;
        end
    end

    // Apply the stack update of a finished word
    always_comb
    begin
        sp_next  = sp_reg;
        top_next = top_reg;
        if (cmd.commit)
        begin
            case (cmd.act)
                rpn_pkg::ACT_PUSH:
                begin
                    sp_next  = sp_reg + SW'(1);
                    top_next = opnd_reg;
                end
                rpn_pkg::ACT_REPLACE:
                begin
                    sp_next  = sp_reg - SW'(1);
                    top_next = res_reg;
                end
                default:
                begin
                    sp_next  = sp_reg;
                    top_next = top_reg;
                end
            endcase
        end
    end

    // Stack pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        a_reg   <= a_next;
        acc_reg <= acc_next;
        shf_reg <= shf_next;
        neg_reg <= neg_next;
        mul_reg <= mul_next;
        res_reg <= res_next;
        sat_reg <= sat_next;
        if (cmd.load_in)
        begin
            opnd_reg <= W'(operand);
        end
        if (cmd.commit)
        begin
            top_value_reg <= (sp_next == '0) ? '0 : rpn_pkg::OPND_W'(top_next);
            depth_reg     <= rpn_pkg::DEPTH_W'(sp_next);
            status_reg    <= cmd.out_status;
        end
    end

    // Entries below the top; push spills the old top
    always_ff @(posedge clk)
    begin
        if (cmd.commit && (cmd.act == rpn_pkg::ACT_PUSH) && (sp_reg != '0))
        begin
            mem[AW'(sp_reg - SW'(1))] <= top_reg;
        end
        rd_reg <= mem[AW'(sp_reg - SW'(2))];
    end

    assign stat.full     = (sp_reg == SW'(STACK_DEPTH));
    assign stat.few      = (sp_reg < SW'(2));
    assign stat.rhs_zero = (top_reg == '0);
    assign stat.sat      = sat_reg;

    assign top_value   = top_value_reg;
    assign stack_depth = depth_reg;
    assign status      = status_reg;

endmodule

// ===== design/rpn_ctrl.sv =====
module rpn_ctrl #(
    parameter int DATA_WIDTH = rpn_pkg::DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rpn_pkg::MODE_W-1:0] mode,
    output logic                       out_valid,
    input  logic                       out_ready,
    input  rpn_pkg::stat_t             stat,
    output rpn_pkg::cmd_t              cmd
);

    localparam int QW = 2 * DATA_WIDTH - DATA_WIDTH / 2;
    localparam int CW = $clog2(QW);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_ITER = 5'b00100,
        S_NORM = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [rpn_pkg::MODE_W-1:0]   mode_reg, mode_next;
    rpn_pkg::act_t                act_reg, act_next;
    logic [rpn_pkg::STATUS_W-1:0] st_reg, st_next;
    logic                         arith_reg, arith_next;
    logic                         div_reg, div_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        act_next       = act_reg;
        st_next        = st_reg;
        arith_next     = arith_reg;
        div_next       = div_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.act        = act_reg;
        cmd.out_status = arith_reg ? (stat.sat ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK) : st_reg;

        // Drop the delivered word
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    mode_next   = mode;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                act_next   = rpn_pkg::ACT_NONE;
                st_next    = rpn_pkg::ST_OK;
                arith_next = 1'b0;
                state_next = S_FIN;
                case (mode_reg)
                    rpn_pkg::MODE_PUSH:
                    begin
                        if (stat.full)
                        begin
                            st_next = rpn_pkg::ST_FULL;
                        end
                        else
                        begin
                            act_next = rpn_pkg::ACT_PUSH;
                        end
                    end
                    rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB:
                    begin
                        if (stat.few)
                        begin
                            st_next = rpn_pkg::ST_UNDER;
                        end
                        else
                        begin
                            cmd.addsub = 1'b1;
                            cmd.sub    = (mode_reg == rpn_pkg::MODE_SUB);
                            act_next   = rpn_pkg::ACT_REPLACE;
                            arith_next = 1'b1;
                        end
                    end
                    rpn_pkg::MODE_MUL:
                    begin
                        if (stat.few)
                        begin
                            st_next = rpn_pkg::ST_UNDER;
                        end
                        else
                        begin
                            cmd.mul_init = 1'b1;
                            act_next     = rpn_pkg::ACT_REPLACE;
                            arith_next   = 1'b1;
                            div_next     = 1'b0;
                            cnt_next     = CW'(DATA_WIDTH - 1);
                            state_next   = S_ITER;
                        end
                    end
                    rpn_pkg::MODE_DIV:
                    begin
                        if (stat.few)
                        begin
                            st_next = rpn_pkg::ST_UNDER;
                        end
                        else if (stat.rhs_zero)
                        begin
                            st_next = rpn_pkg::ST_DIVZ;
                        end
                        else
                        begin
                            cmd.div_init = 1'b1;
                            act_next     = rpn_pkg::ACT_REPLACE;
                            arith_next   = 1'b1;
                            div_next     = 1'b1;
                            cnt_next     = CW'(QW - 1);
                            state_next   = S_ITER;
                        end
                    end
                    default:
                    begin
                        st_next = rpn_pkg::ST_OK;
                    end
                endcase
            end
            S_ITER:
            begin
                cmd.mul_step = !div_reg;
                cmd.div_step = div_reg;
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.norm   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Hold until the output register is free
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            act_reg       <= rpn_pkg::ACT_NONE;
            st_reg        <= rpn_pkg::ST_OK;
            arith_reg     <= 1'b0;
            div_reg       <= 1'b0;
            cnt_reg       <= '0;
            mode_reg      <= rpn_pkg::MODE_PUSH;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            act_reg       <= act_next;
            st_reg        <= st_next;
            arith_reg     <= arith_next;
            div_reg       <= div_next;
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
        end
    end

endmodule

// ===== design/rpn_stack_evaluator.sv =====
// Push, add, subtract and all error cases pass the controller states EXEC and FIN;
// multiply and divide also pass ITER and NORM. FIN holds while a result word is stalled.
// One word in flight: the next word is taken only after the result is registered.
// The shared shift-add / restoring divide unit works one bit per cycle.
// Reset (rst_n, async, active low) empties the stack; memory contents are not cleared.
module rpn_stack_evaluator #(
    parameter int DATA_WIDTH  = rpn_pkg::DATA_WIDTH_DEF,
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input logic   clk,
    input logic   rst_n,
    rpn_in_if.sink    in_ch,
    rpn_out_if.source out_ch
);

    rpn_pkg::cmd_t  cmd;
    rpn_pkg::stat_t stat;

    rpn_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .mode      (in_ch.mode),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rpn_dpath #(
        .DATA_WIDTH  (DATA_WIDTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operand     (in_ch.operand),
        .top_value   (out_ch.top_value),
        .stack_depth (out_ch.stack_depth),
        .status      (out_ch.status)
    );

endmodule

// ===== design/rpn_checker.sv =====
module rpn_checker #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [rpn_pkg::OPND_W-1:0]  top_value,
    input logic [rpn_pkg::DEPTH_W-1:0]        stack_depth,
    input logic [rpn_pkg::STATUS_W-1:0]       status
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(top_value)
            && $stable(stack_depth) && $stable(status))
        else $error("result word changed while stalled");

    // One word in flight: no accept on the cycle after an accept
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in flight");

    // Underflow only below two entries
    a_under: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == rpn_pkg::ST_UNDER) |-> stack_depth < 5'd2)
        else $error("underflow reported with two or more entries");

    // Full only at the full depth
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == rpn_pkg::ST_FULL)
            |-> stack_depth == rpn_pkg::DEPTH_W'(STACK_DEPTH))
        else $error("stack full reported below the full depth");

    // Empty stack shows zero on top
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (stack_depth == '0) && (STACK_DEPTH < 32) |-> top_value == '0)
        else $error("empty stack with nonzero top");

endmodule

bind rpn_stack_evaluator rpn_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_rpn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .top_value   (out_ch.top_value),
    .stack_depth (out_ch.stack_depth),
    .status      (out_ch.status)
);
